// ----- rtl/core/qsma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad shell mass apply package
// Shared constants, quadrature tables, micro-op encoding and the command and
// status types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qsma_pkg;

  localparam int QUAD_POINTS = 6;
  localparam int NUM_OPS     = 35;
  localparam int POINT_W     = $clog2(QUAD_POINTS);
  localparam int OP_W        = $clog2(NUM_OPS);
  localparam int PROD_W      = 66;
  localparam int ACC_W       = 52;
  localparam int OUT_W       = 48;

  localparam logic [30:0] QONE = 31'h4000_0000;

  typedef logic [29:0] qc_t;

  // Quadrature coordinates and weights, unsigned Q0.30.
  localparam qc_t PT_X [QUAD_POINTS] = '{
    30'd536870912, 30'd1055537489, 30'd781471301,
    30'd781471301, 30'd144080073, 30'd144080073};
  localparam qc_t PT_Y [QUAD_POINTS] = '{
    30'd536870912, 30'd536870912, 30'd79502715,
    30'd994239109, 30'd198152188, 30'd875589636};
  localparam qc_t PT_W [QUAD_POINTS] = '{
    30'd306783378, 30'd117993607, 30'd151953851,
    30'd151953851, 30'd172528568, 30'd172528568};

  typedef logic [30:0] nb_t;
  typedef nb_t [3:0] nb_row_t;
  typedef nb_row_t [QUAD_POINTS-1:0] nb_tab_t;

  function automatic nb_t mulq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + 64'h2000_0000;
    return nb_t'(p >> 30);
  endfunction

  // Bilinear basis values at each quadrature point, built at elaboration.
  function automatic nb_tab_t nb_table();
    nb_tab_t t;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] ox;
    logic [63:0] oy;
    for (int q = 0; q < QUAD_POINTS; q++) begin
      x  = {34'd0, PT_X[q]};
      y  = {34'd0, PT_Y[q]};
      ox = {33'd0, QONE} - x;
      oy = {33'd0, QONE} - y;
      t[q][0] = mulq(ox, oy);
      t[q][1] = mulq(x, oy);
      t[q][2] = mulq(x, y);
      t[q][3] = mulq(ox, y);
    end
    return t;
  endfunction

  localparam nb_tab_t NB_TAB = nb_table();

  typedef enum logic [5:0] {
    SEL_D30X, SEL_D30Y, SEL_D30Z, SEL_D21X, SEL_D21Y, SEL_D21Z,
    SEL_D10X, SEL_D10Y, SEL_D10Z, SEL_D23X, SEL_D23Y, SEL_D23Z,
    SEL_AX, SEL_AY, SEL_AZ, SEL_BX, SEL_BY, SEL_BZ,
    SEL_C0, SEL_C1, SEL_C2,
    SEL_OMQX, SEL_QX, SEL_OMQY, SEL_QY,
    SEL_W, SEL_AREA, SEL_NB, SEL_U, SEL_WA, SEL_UH, SEL_MLO, SEL_MHI
  } sel_e;

  typedef enum logic [1:0] {MODE_LOAD, MODE_ADD, MODE_SUB} mode_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_AX, DST_AY, DST_AZ, DST_BX, DST_BY, DST_BZ,
    DST_C0, DST_C1, DST_C2, DST_SQ, DST_WA, DST_UH, DST_M, DST_R, DST_ACC
  } dst_e;

  typedef struct packed {
    sel_e       a;
    sel_e       b;
    mode_e      mode;
    dst_e       dst;
    logic [1:0] nidx;
  } op_t;

  typedef struct packed {
    logic               corner_we;
    logic               clear_acc;
    logic               mul_en;
    logic               post_en;
    logic               sqrt_start;
    logic               out_load;
    logic [1:0]         out_idx;
    logic [POINT_W-1:0] point;
    op_t                op;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } status_t;

  function automatic op_t mk(input sel_e a, input sel_e b, input mode_e m,
                             input dst_e d, input logic [1:0] n);
    op_t o;
    o.a    = a;
    o.b    = b;
    o.mode = m;
    o.dst  = d;
    o.nidx = n;
    return o;
  endfunction

  // Micro-program for one quadrature point. The square root runs after the
  // op that writes the squared cross magnitude.
  function automatic op_t op_table(input logic [OP_W-1:0] idx);
    op_t o;
    case (idx)
      6'd0:  o = mk(SEL_D30X, SEL_OMQX, MODE_LOAD, DST_NONE, 2'd0);
      6'd1:  o = mk(SEL_D21X, SEL_QX,   MODE_ADD,  DST_AX,   2'd0);
      6'd2:  o = mk(SEL_D30Y, SEL_OMQX, MODE_LOAD, DST_NONE, 2'd0);
      6'd3:  o = mk(SEL_D21Y, SEL_QX,   MODE_ADD,  DST_AY,   2'd0);
      6'd4:  o = mk(SEL_D30Z, SEL_OMQX, MODE_LOAD, DST_NONE, 2'd0);
      6'd5:  o = mk(SEL_D21Z, SEL_QX,   MODE_ADD,  DST_AZ,   2'd0);
      6'd6:  o = mk(SEL_D10X, SEL_OMQY, MODE_LOAD, DST_NONE, 2'd0);
      6'd7:  o = mk(SEL_D23X, SEL_QY,   MODE_ADD,  DST_BX,   2'd0);
      6'd8:  o = mk(SEL_D10Y, SEL_OMQY, MODE_LOAD, DST_NONE, 2'd0);
      6'd9:  o = mk(SEL_D23Y, SEL_QY,   MODE_ADD,  DST_BY,   2'd0);
      6'd10: o = mk(SEL_D10Z, SEL_OMQY, MODE_LOAD, DST_NONE, 2'd0);
      6'd11: o = mk(SEL_D23Z, SEL_QY,   MODE_ADD,  DST_BZ,   2'd0);
      6'd12: o = mk(SEL_AY,   SEL_BZ,   MODE_LOAD, DST_NONE, 2'd0);
      6'd13: o = mk(SEL_AZ,   SEL_BY,   MODE_SUB,  DST_C0,   2'd0);
      6'd14: o = mk(SEL_AZ,   SEL_BX,   MODE_LOAD, DST_NONE, 2'd0);
      6'd15: o = mk(SEL_AX,   SEL_BZ,   MODE_SUB,  DST_C1,   2'd0);
      6'd16: o = mk(SEL_AX,   SEL_BY,   MODE_LOAD, DST_NONE, 2'd0);
      6'd17: o = mk(SEL_AY,   SEL_BX,   MODE_SUB,  DST_C2,   2'd0);
      6'd18: o = mk(SEL_C0,   SEL_C0,   MODE_LOAD, DST_NONE, 2'd0);
      6'd19: o = mk(SEL_C1,   SEL_C1,   MODE_ADD,  DST_NONE, 2'd0);
      6'd20: o = mk(SEL_C2,   SEL_C2,   MODE_ADD,  DST_SQ,   2'd0);
      6'd21: o = mk(SEL_W,    SEL_AREA, MODE_LOAD, DST_WA,   2'd0);
      6'd22: o = mk(SEL_NB,   SEL_U,    MODE_LOAD, DST_NONE, 2'd0);
      6'd23: o = mk(SEL_NB,   SEL_U,    MODE_ADD,  DST_NONE, 2'd1);
      6'd24: o = mk(SEL_NB,   SEL_U,    MODE_ADD,  DST_NONE, 2'd2);
      6'd25: o = mk(SEL_NB,   SEL_U,    MODE_ADD,  DST_UH,   2'd3);
      6'd26: o = mk(SEL_WA,   SEL_UH,   MODE_LOAD, DST_M,    2'd0);
      6'd27: o = mk(SEL_NB,   SEL_MLO,  MODE_LOAD, DST_R,    2'd0);
      6'd28: o = mk(SEL_NB,   SEL_MHI,  MODE_LOAD, DST_ACC,  2'd0);
      6'd29: o = mk(SEL_NB,   SEL_MLO,  MODE_LOAD, DST_R,    2'd1);
      6'd30: o = mk(SEL_NB,   SEL_MHI,  MODE_LOAD, DST_ACC,  2'd1);
      6'd31: o = mk(SEL_NB,   SEL_MLO,  MODE_LOAD, DST_R,    2'd2);
      6'd32: o = mk(SEL_NB,   SEL_MHI,  MODE_LOAD, DST_ACC,  2'd2);
      6'd33: o = mk(SEL_NB,   SEL_MLO,  MODE_LOAD, DST_R,    2'd3);
      6'd34: o = mk(SEL_NB,   SEL_MHI,  MODE_LOAD, DST_ACC,  2'd3);
      default: o = mk(SEL_D30X, SEL_D30X, MODE_LOAD, DST_NONE, 2'd0);
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qsma_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad shell mass apply square root unit
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module qsma_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic      [31:0] root_o,
  output logic             done_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [63:0] trial;

  always_comb begin
    trial  = res_q + bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = radicand_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 64'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q[31:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- rtl/core/qsma_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad shell mass apply datapath
// Corner storage, shared multiplier, rounding post-processor, square root
// unit, per-corner accumulators and the output register.
// ----------------------------------------------------------------------------
module qsma_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire qsma_pkg::cmd_t              cmd_i,
  output qsma_pkg::status_t                status_o,
  input  wire logic signed [31:0]          node_x_i,
  input  wire logic signed [31:0]          node_y_i,
  input  wire logic signed [31:0]          node_z_i,
  input  wire logic signed [31:0]          node_value_i,
  input  wire logic        [1:0]           node_slot_i,
  output logic signed [qsma_pkg::OUT_W-1:0] out_value_o,
  output logic        [1:0]                out_slot_o,
  output logic                             out_last_o
);

  localparam int PW = qsma_pkg::PROD_W;
  localparam int AW = qsma_pkg::ACC_W;
  localparam int OW = qsma_pkg::OUT_W;

  logic signed [31:0] cx_q [4];
  logic signed [31:0] cy_q [4];
  logic signed [31:0] cz_q [4];
  logic signed [31:0] cu_q [4];

  logic signed [32:0] d30x, d30y, d30z, d21x, d21y, d21z;
  logic signed [32:0] d10x, d10y, d10z, d23x, d23y, d23z;

  logic signed [31:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic        [30:0] c0_q, c1_q, c2_q;
  logic        [63:0] sq_q;
  logic        [31:0] wa_q;
  logic signed [31:0] uh_q;
  logic        [31:0] mhi_q;
  logic        [15:0] mlo_q;
  logic               msign_q;
  logic        [31:0] r_q;
  logic signed [AW-1:0] sum_q [4];

  logic signed [PW-1:0] prod_q, acc_q, acc_new, prod_d;
  logic signed [32:0]   opa, opb;
  logic        [PW-1:0] mag, tmp30, tmp16;
  logic        [35:0]   r30;
  logic        [49:0]   r16;
  logic signed [31:0]   tan_sat;
  logic        [30:0]   cross_sat;
  logic        [63:0]   scl_sum;
  logic signed [AW-1:0] scaled, scaled_s;

  logic        [29:0] qx, qy, qw;
  logic        [30:0] omqx, omqy, nb;
  logic        [31:0] root;
  logic signed [AW-1:0] osel;

  assign qx   = qsma_pkg::PT_X[cmd_i.point];
  assign qy   = qsma_pkg::PT_Y[cmd_i.point];
  assign qw   = qsma_pkg::PT_W[cmd_i.point];
  assign omqx = qsma_pkg::QONE - {1'b0, qx};
  assign omqy = qsma_pkg::QONE - {1'b0, qy};
  assign nb   = qsma_pkg::NB_TAB[cmd_i.point][cmd_i.op.nidx];

  assign d30x = {cx_q[3][31], cx_q[3]} - {cx_q[0][31], cx_q[0]};
  assign d30y = {cy_q[3][31], cy_q[3]} - {cy_q[0][31], cy_q[0]};
  assign d30z = {cz_q[3][31], cz_q[3]} - {cz_q[0][31], cz_q[0]};
  assign d21x = {cx_q[2][31], cx_q[2]} - {cx_q[1][31], cx_q[1]};
  assign d21y = {cy_q[2][31], cy_q[2]} - {cy_q[1][31], cy_q[1]};
  assign d21z = {cz_q[2][31], cz_q[2]} - {cz_q[1][31], cz_q[1]};
  assign d10x = {cx_q[1][31], cx_q[1]} - {cx_q[0][31], cx_q[0]};
  assign d10y = {cy_q[1][31], cy_q[1]} - {cy_q[0][31], cy_q[0]};
  assign d10z = {cz_q[1][31], cz_q[1]} - {cz_q[0][31], cz_q[0]};
  assign d23x = {cx_q[2][31], cx_q[2]} - {cx_q[3][31], cx_q[3]};
  assign d23y = {cy_q[2][31], cy_q[2]} - {cy_q[3][31], cy_q[3]};
  assign d23z = {cz_q[2][31], cz_q[2]} - {cz_q[3][31], cz_q[3]};

  function automatic logic signed [32:0] pick(input qsma_pkg::sel_e sel);
    logic signed [32:0] v;
    case (sel)
      qsma_pkg::SEL_D30X: v = d30x;
      qsma_pkg::SEL_D30Y: v = d30y;
      qsma_pkg::SEL_D30Z: v = d30z;
      qsma_pkg::SEL_D21X: v = d21x;
      qsma_pkg::SEL_D21Y: v = d21y;
      qsma_pkg::SEL_D21Z: v = d21z;
      qsma_pkg::SEL_D10X: v = d10x;
      qsma_pkg::SEL_D10Y: v = d10y;
      qsma_pkg::SEL_D10Z: v = d10z;
      qsma_pkg::SEL_D23X: v = d23x;
      qsma_pkg::SEL_D23Y: v = d23y;
      qsma_pkg::SEL_D23Z: v = d23z;
      qsma_pkg::SEL_AX:   v = {ax_q[31], ax_q};
      qsma_pkg::SEL_AY:   v = {ay_q[31], ay_q};
      qsma_pkg::SEL_AZ:   v = {az_q[31], az_q};
      qsma_pkg::SEL_BX:   v = {bx_q[31], bx_q};
      qsma_pkg::SEL_BY:   v = {by_q[31], by_q};
      qsma_pkg::SEL_BZ:   v = {bz_q[31], bz_q};
      qsma_pkg::SEL_C0:   v = {2'b00, c0_q};
      qsma_pkg::SEL_C1:   v = {2'b00, c1_q};
      qsma_pkg::SEL_C2:   v = {2'b00, c2_q};
      qsma_pkg::SEL_OMQX: v = {2'b00, omqx};
      qsma_pkg::SEL_QX:   v = {3'b000, qx};
      qsma_pkg::SEL_OMQY: v = {2'b00, omqy};
      qsma_pkg::SEL_QY:   v = {3'b000, qy};
      qsma_pkg::SEL_W:    v = {3'b000, qw};
      qsma_pkg::SEL_AREA: v = {1'b0, root};
      qsma_pkg::SEL_NB:   v = {2'b00, nb};
      qsma_pkg::SEL_U:    v = {cu_q[cmd_i.op.nidx][31], cu_q[cmd_i.op.nidx]};
      qsma_pkg::SEL_WA:   v = {1'b0, wa_q};
      qsma_pkg::SEL_UH:   v = {uh_q[31], uh_q};
      qsma_pkg::SEL_MLO:  v = {17'd0, mlo_q};
      qsma_pkg::SEL_MHI:  v = {1'b0, mhi_q};
      default:            v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa    = pick(cmd_i.op.a);
    opb    = pick(cmd_i.op.b);
    prod_d = opa * opb;
  end

  // Post-processing: load, add or subtract the product, then derive every rounded form
  // that a destination may need. All roundings are half away from zero.
  always_comb begin
    case (cmd_i.op.mode)
      qsma_pkg::MODE_LOAD: acc_new = prod_q;
      qsma_pkg::MODE_ADD:  acc_new = acc_q + prod_q;
      qsma_pkg::MODE_SUB:  acc_new = acc_q - prod_q;
      default:             acc_new = prod_q;
    endcase
    mag   = acc_new[PW-1] ? PW'(-acc_new) : PW'(acc_new);
    tmp30 = mag + PW'(64'h2000_0000);
    tmp16 = mag + PW'(64'h8000);
    r30   = tmp30[PW-1:30];
    r16   = tmp16[PW-1:16];
    if (acc_new[PW-1]) begin
      tan_sat = (r30 > 36'h0_8000_0000) ? 32'sh8000_0000 : -$signed(r30[31:0]);
    end else begin
      tan_sat = (r30 > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r30[31:0]);
    end
    cross_sat = (r16 > 50'h7FFF_FFFF) ? 31'h7FFF_FFFF : r16[30:0];
    scl_sum   = acc_new[63:0] + {32'd0, r_q};
    scaled    = AW'({2'b00, scl_sum[63:14]});
    scaled_s  = msign_q ? -scaled : scaled;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.corner_we) begin
      cx_q[node_slot_i] <= node_x_i;
      cy_q[node_slot_i] <= node_y_i;
      cz_q[node_slot_i] <= node_z_i;
      cu_q[node_slot_i] <= node_value_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.post_en) begin
      acc_q <= acc_new;
      case (cmd_i.op.dst)
        qsma_pkg::DST_AX: ax_q <= tan_sat;
        qsma_pkg::DST_AY: ay_q <= tan_sat;
        qsma_pkg::DST_AZ: az_q <= tan_sat;
        qsma_pkg::DST_BX: bx_q <= tan_sat;
        qsma_pkg::DST_BY: by_q <= tan_sat;
        qsma_pkg::DST_BZ: bz_q <= tan_sat;
        qsma_pkg::DST_C0: c0_q <= cross_sat;
        qsma_pkg::DST_C1: c1_q <= cross_sat;
        qsma_pkg::DST_C2: c2_q <= cross_sat;
        qsma_pkg::DST_SQ: sq_q <= acc_new[63:0];
        qsma_pkg::DST_WA: wa_q <= r30[31:0];
        qsma_pkg::DST_UH: uh_q <= tan_sat;
        qsma_pkg::DST_M: begin
          mhi_q   <= r16[47:16];
          mlo_q   <= r16[15:0];
          msign_q <= acc_new[PW-1];
        end
        qsma_pkg::DST_R:   r_q <= tmp30[47:16];
        qsma_pkg::DST_ACC: sum_q[cmd_i.op.nidx] <= sum_q[cmd_i.op.nidx] + scaled_s;
        default: ;
      endcase
    end
    if (cmd_i.clear_acc) begin
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_value_o <= $signed(osel[OW-1:0]);
      out_slot_o  <= cmd_i.out_idx;
      out_last_o  <= (cmd_i.out_idx == 2'd3);
    end
  end

  // Saturate the selected accumulator to the 48-bit result range.
  always_comb begin
    osel = sum_q[cmd_i.out_idx];
    if (osel > AW'(64'sh7FFF_FFFF_FFFF)) begin
      osel = AW'(64'sh7FFF_FFFF_FFFF);
    end else if (osel < -AW'(64'sh8000_0000_0000)) begin
      osel = -AW'(64'sh8000_0000_0000);
    end
  end

  qsma_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (sq_q),
    .root_o     (root),
    .done_o     (status_o.sqrt_done)
  );

endmodule
`default_nettype wire

// ----- rtl/core/qsma_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad shell mass apply controller
// Sequences corner loads, the per-point micro-program, the square root and
// the four result items.
// ----------------------------------------------------------------------------
module qsma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              node_valid_i,
  input  wire logic [1:0]        node_slot_i,
  output logic                   node_stall_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output qsma_pkg::cmd_t         cmd_o,
  input  wire qsma_pkg::status_t status_i
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MUL       = 3'd1;
  localparam logic [2:0] S_POST      = 3'd2;
  localparam logic [2:0] S_SQRT_GO   = 3'd3;
  localparam logic [2:0] S_SQRT_WAIT = 3'd4;
  localparam logic [2:0] S_OUT       = 3'd5;

  localparam int PTW = qsma_pkg::POINT_W;
  localparam int OPW = qsma_pkg::OP_W;

  logic [2:0]     state_q, state_d;
  logic [OPW-1:0] op_q, op_d;
  logic [PTW-1:0] point_q, point_d;
  logic [1:0]     oidx_q, oidx_d;
  logic           out_valid_q, out_valid_d;
  qsma_pkg::op_t  op;

  assign op = qsma_pkg::op_table(op_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    point_d     = point_q;
    oidx_d      = oidx_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.point = point_q;
    cmd_o.op    = op;
    case (state_q)
      S_IDLE: begin
        if (node_valid_i) begin
          cmd_o.corner_we = 1'b1;
          if (node_slot_i == 2'd3) begin
            cmd_o.clear_acc = 1'b1;
            point_d = '0;
            op_d    = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_POST;
      end
      S_POST: begin
        cmd_o.post_en = 1'b1;
        if (op.dst == qsma_pkg::DST_SQ) begin
          state_d = S_SQRT_GO;
        end else if (op_q == OPW'(qsma_pkg::NUM_OPS - 1)) begin
          if (point_q == PTW'(qsma_pkg::QUAD_POINTS - 1)) begin
            cmd_o.out_load = 1'b1;
            oidx_d         = 2'd0;
            out_valid_d    = 1'b1;
            state_d        = S_OUT;
          end else begin
            point_d = point_q + 1'b1;
            op_d    = '0;
            state_d = S_MUL;
          end
        end else begin
          op_d    = op_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        op_d             = op_q + 1'b1;
        state_d          = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (status_i.sqrt_done) begin
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (oidx_q == 2'd3) begin
            out_valid_d = 1'b0;
            state_d     = S_IDLE;
          end else begin
            oidx_d         = oidx_q + 1'b1;
            cmd_o.out_load = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.out_idx = oidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      point_q     <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      point_q     <= point_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign node_stall_o = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/quad_shell_mass_apply_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input: a corner item with slot 0 to 2 is taken and stored and gives no result.
// A slot 3 item starts the element: six quadrature points, each of 35 multiply
// ops on the one shared multiplier plus a square root. The element gives four
// result items; no new element is taken until the fourth has been taken.
// Reset: rst_ni is asynchronous, active low, and clears the control state only.
// ----------------------------------------------------------------------------
// Quad shell mass apply top level
// Mass-matrix apply for one bilinear quad shell element in 3D, Q16.16.
// ----------------------------------------------------------------------------
module quad_shell_mass_apply_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         node_valid_i,
  output logic                              node_stall_o,
  input  wire logic signed [31:0]           node_x_i,
  input  wire logic signed [31:0]           node_y_i,
  input  wire logic signed [31:0]           node_z_i,
  input  wire logic signed [31:0]           node_value_i,
  input  wire logic        [1:0]            node_slot_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [qsma_pkg::OUT_W-1:0] out_value_o,
  output logic        [1:0]                 out_slot_o,
  output logic                              out_last_o
);

  // The controller steps through a fixed micro-program per quadrature point.
  // Each op multiplies two selected operands into a register and rounds or
  // accumulates the product in the following cycle. The input channel is stalled from
  // the slot 3 item until the fourth result item has been taken.
  qsma_pkg::cmd_t    cmd;
  qsma_pkg::status_t status;

  qsma_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_valid_i (node_valid_i),
    .node_slot_i  (node_slot_i),
    .node_stall_o (node_stall_o),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // The datapath holds the corners, the intermediate values of one point,
  // the four per-corner sums and the output register that results leave by.
  qsma_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .node_x_i     (node_x_i),
    .node_y_i     (node_y_i),
    .node_z_i     (node_z_i),
    .node_value_i (node_value_i),
    .node_slot_i  (node_slot_i),
    .out_value_o  (out_value_o),
    .out_slot_o   (out_slot_o),
    .out_last_o   (out_last_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/qsma_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad shell mass apply checker
// Port-level properties of the result sequence, bound to the top level.
// ----------------------------------------------------------------------------
module qsma_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        node_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [47:0] out_value_o,
  input wire logic [1:0]  out_slot_o,
  input wire logic        out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(out_slot_o))
    else $error("stalled result item changed");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (out_slot_o == 2'd3)))
    else $error("last flag does not match corner three");

  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_stall_o)
    else $error("input taken while results pending");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=>
      out_valid_o && (out_slot_o == 2'($past(out_slot_o) + 2'd1)))
    else $error("result items out of corner order");

endmodule

bind quad_shell_mass_apply_top qsma_checker u_qsma_checker (.*);
`default_nettype wire
